// ===== hdl/csvfs_pkg.sv =====
// Shared types, constants and helpers for the CSV field splitter.
package csvfs_pkg;

  localparam int MAX_FIELDS = 256;
  localparam int IndexW = 8;
  localparam int IndexCapInt = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;
  localparam logic [IndexW-1:0] IndexCap = IndexW'(IndexCapInt);

  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharQuote = 8'h22;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    QS_UNQUOTED,
    QS_QUOTED,
    QS_QUOTE_SEEN
  } quote_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in_row;
    logic       empty_row;
  } in_item_t;

  typedef struct packed {
    logic              has_char;
    logic [7:0]        out_char;
    logic [IndexW-1:0] field_index;
    logic              field_end;
    logic              row_end;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic              pri_valid;
    logic              pri_has_char;
    logic [7:0]        pri_char;
    logic [IndexW-1:0] pri_index;
    logic              pri_field_end;
    logic              sec_valid;
    logic [IndexW-1:0] sec_index;
  } entry_t;

  function automatic logic [IndexW-1:0] next_index(input logic [IndexW-1:0] idx);
    logic [IndexW-1:0] res;
    res = (idx < IndexCap) ? idx + IndexW'(1) : idx;
    return res;
  endfunction

endpackage

// ===== hdl/csvfs_front.sv =====
// Front end: accept row bytes, track quoting and field index, build result entries.
module csvfs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  csvfs_pkg::in_item_t item,
  input  logic               q_full,
  output logic               full,
  output logic               ent_push,
  output csvfs_pkg::entry_t  ent
);
  import csvfs_pkg::*;

  quote_state_t      quote_state, quote_state_next;
  logic [IndexW-1:0] field_counter, field_counter_next;
  logic              accept;
  logic              is_comma, is_quote;

  assign accept   = push && !q_full;
  assign full     = q_full;
  assign is_comma = (item.in_byte == CharComma);
  assign is_quote = (item.in_byte == CharQuote);

  always_comb begin
    quote_state_next   = quote_state;
    field_counter_next = field_counter;
    if (accept) begin
      if (item.empty_row) begin
        quote_state_next   = QS_UNQUOTED;
        field_counter_next = '0;
      end else begin
        unique case (quote_state)
          QS_QUOTED: begin
            if (is_quote) quote_state_next = QS_QUOTE_SEEN;
          end
          QS_QUOTE_SEEN: begin
            if (is_comma) begin
              quote_state_next   = QS_UNQUOTED;
              field_counter_next = next_index(field_counter);
            end else if (is_quote) begin
              quote_state_next = QS_QUOTED;
            end else begin
              quote_state_next = QS_UNQUOTED;
            end
          end
          default: begin
            if (is_comma) begin
              field_counter_next = next_index(field_counter);
            end else if (is_quote) begin
              quote_state_next = QS_QUOTED;
            end
          end
        endcase
        if (item.last_in_row) begin
          quote_state_next   = QS_UNQUOTED;
          field_counter_next = '0;
        end
      end
    end
  end

  always_comb begin
    ent               = '0;
    ent.pri_index     = field_counter;
    ent.sec_index     = field_counter;
    if (item.empty_row) begin
      ent.sec_valid = 1'b1;
    end else begin
      unique case (quote_state)
        QS_QUOTED: begin
          if (!is_quote) begin
            ent.pri_valid    = 1'b1;
            ent.pri_has_char = 1'b1;
            ent.pri_char     = item.in_byte;
          end
        end
        QS_QUOTE_SEEN: begin
          if (is_comma) begin
            ent.pri_valid     = 1'b1;
            ent.pri_field_end = 1'b1;
          end else if (is_quote) begin
            ent.pri_valid    = 1'b1;
            ent.pri_has_char = 1'b1;
            ent.pri_char     = CharQuote;
          end
        end
        default: begin
          if (is_comma) begin
            ent.pri_valid     = 1'b1;
            ent.pri_field_end = 1'b1;
          end else if (!is_quote) begin
            ent.pri_valid    = 1'b1;
            ent.pri_has_char = 1'b1;
            ent.pri_char     = item.in_byte;
          end
        end
      endcase
      ent.sec_valid = item.last_in_row;
      if (ent.pri_field_end) ent.sec_index = next_index(field_counter);
    end
    ent_push = accept && (ent.pri_valid || ent.sec_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_state   <= QS_UNQUOTED;
      field_counter <= '0;
    end else begin
      quote_state   <= quote_state_next;
      field_counter <= field_counter_next;
    end
  end

endmodule

// ===== hdl/csvfs_queue.sv =====
// Short entry queue between the front and back ends.
module csvfs_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  csvfs_pkg::entry_t wr_entry,
  input  logic              rd,
  output csvfs_pkg::entry_t rd_entry,
  output logic              full,
  output logic              empty
);
  import csvfs_pkg::*;

  entry_t               mem [QueueDepth];
  logic [QueuePtrW-1:0] wptr, rptr;
  logic [QueuePtrW:0]   count;
  logic                 do_wr, do_rd;

  assign full     = (count == (QueuePtrW+1)'(QueueDepth));
  assign empty    = (count == '0);
  assign do_wr    = wr && !full;
  assign do_rd    = rd && !empty;
  assign rd_entry = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + QueuePtrW'(1);
      if (do_rd) rptr <= rptr + QueuePtrW'(1);
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + (QueuePtrW+1)'(1);
        2'b01:   count <= count - (QueuePtrW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/csvfs_back.sv =====
// Back end: split entries into one or two results and hold them in an output register.
module csvfs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  csvfs_pkg::entry_t   q_entry,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output csvfs_pkg::out_item_t result
);
  import csvfs_pkg::*;

  logic              out_valid, out_valid_next;
  out_item_t         out_res, out_res_next;
  logic              pend_valid, pend_valid_next;
  logic [IndexW-1:0] pend_index, pend_index_next;
  logic              load;

  assign load   = !out_valid || pop;
  assign empty  = !out_valid;
  assign result = out_res;

  always_comb begin
    out_valid_next  = out_valid && !pop;
    out_res_next    = out_res;
    pend_valid_next = pend_valid;
    pend_index_next = pend_index;
    q_pop           = 1'b0;
    if (load) begin
      if (pend_valid) begin
        out_valid_next           = 1'b1;
        out_res_next             = '0;
        out_res_next.field_index = pend_index;
        out_res_next.field_end   = 1'b1;
        out_res_next.row_end     = 1'b1;
        out_res_next.last        = 1'b1;
        pend_valid_next          = 1'b0;
      end else if (!q_empty) begin
        q_pop          = 1'b1;
        out_valid_next = 1'b1;
        out_res_next   = '0;
        if (q_entry.pri_valid) begin
          out_res_next.has_char    = q_entry.pri_has_char;
          out_res_next.out_char    = q_entry.pri_char;
          out_res_next.field_index = q_entry.pri_index;
          out_res_next.field_end   = q_entry.pri_field_end;
          out_res_next.last        = !q_entry.sec_valid;
          pend_valid_next          = q_entry.sec_valid;
          pend_index_next          = q_entry.sec_index;
        end else begin
          out_res_next.field_index = q_entry.sec_index;
          out_res_next.field_end   = 1'b1;
          out_res_next.row_end     = 1'b1;
          out_res_next.last        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res    <= out_res_next;
    pend_index <= pend_index_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      pend_valid <= pend_valid_next;
    end
  end

endmodule

// ===== hdl/csv_field_splitter.sv =====
// Top level of the CSV field splitter: front end, entry queue and back end.
// Bytes of a row enter one per cycle through push/full while full is low; a classifier
// tracks the quote state and field index and writes each byte's results (a content
// byte or comma field-end, then a row-end field-end on the last byte) as one entry
// into a four-entry queue. The back end reads at most one entry per cycle and drives
// results through an output register with pop/empty. An entry with two results fills
// the output register with each in turn, so a row of N bytes gives at most N+1 results.
// A byte's entry is written into the queue when the byte is accepted and is loaded
// from there into the output register once it is free. Bytes that give no result
// (opening quotes, a quote inside a quoted field, a stray byte after a closing quote)
// write no entry.
module csv_field_splitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  csvfs_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output csvfs_pkg::out_item_t result
);
  import csvfs_pkg::*;

  logic   ent_push, q_full, q_empty, q_pop;
  entry_t ent, q_entry;

  csvfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .q_full   (q_full),
    .full     (full),
    .ent_push (ent_push),
    .ent      (ent)
  );

  csvfs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (ent_push),
    .wr_entry (ent),
    .rd       (q_pop),
    .rd_entry (q_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  csvfs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  a_row_end_closes: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.row_end) |-> (result.field_end && result.last && !result.has_char))
    else $error("row end result without field end or last");

  a_char_not_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.has_char) |-> (!result.field_end && !result.row_end))
    else $error("content result marked as field end");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    ent_push |-> !q_full)
    else $error("entry written into a full queue");

  a_empty_row_result: assert property (@(posedge clk) disable iff (rst)
    (push && !full && item.empty_row) |=> !q_empty)
    else $error("empty row left no entry");

endmodule
